FILE: rtl/smoothed_gain_spatial_mixer_defines.svh
// Assertion macros for the smoothed-gain spatial mixer.
// Depends on nothing; the asserting module must have clk_i and rst_ni in scope.
`ifndef SMOOTHED_GAIN_SPATIAL_MIXER_DEFINES_SVH
`define SMOOTHED_GAIN_SPATIAL_MIXER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SGSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SGSM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sgsm_pkg.sv
// Shared types, constants and the product schedule of the spatial mixer.
// Used by the request channel interface and the top level; depends on nothing.
package sgsm_pkg;

  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned GAIN_COUNT  = 8;
  localparam int unsigned GIDX_W      = 3;
  localparam logic [GIDX_W-1:0] GIDX_DRY   = 3'd0;
  localparam logic [GIDX_W-1:0] GIDX_LEFT  = 3'd1;
  localparam logic [GIDX_W-1:0] GIDX_RIGHT = 3'd2;
  localparam logic [GIDX_W-1:0] GIDX_DIST  = 3'd3;
  localparam logic [GIDX_W-1:0] GIDX_DIR   = 3'd4;
  localparam logic [GIDX_W-1:0] GIDX_SEND_A = 3'd5;
  localparam logic [GIDX_W-1:0] GIDX_SEND_B = 3'd6;
  localparam logic [GIDX_W-1:0] GIDX_SEND_C = 3'd7;
  localparam logic [GAIN_W-1:0] MIN_DRY_GAIN = 16'd3;

  // Configuration registers.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [1:0] REG_STEP = 2'd0;
  localparam logic [1:0] REG_WET  = 2'd1;
  localparam logic [1:0] REG_MUTE = 2'd2;
  localparam logic [1:0] REG_SPAT = 2'd3;
  localparam logic [15:0] STEP_RST = 16'd64;
  localparam logic [15:0] WET_RST  = 16'd410;

  // Digit-serial multiplier: the B operand is a 20-bit signed word taken
  // four bits a cycle, most significant digit first.
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned NUM_DIG = 5;
  localparam int unsigned BOP_W   = DIG_W * NUM_DIG;
  localparam int unsigned CNT_W   = 3;
  localparam logic [CNT_W-1:0] CNT_LOAD  = 3'd0;
  localparam logic [CNT_W-1:0] CNT_FIRST = 3'd1;
  localparam logic [CNT_W-1:0] CNT_WB    = 3'(NUM_DIG + 1);

  localparam int unsigned OP_W       = 5;
  localparam int unsigned NUM_OPS    = 19;
  localparam logic [OP_W-1:0] OP_LAST       = 5'(NUM_OPS - 1);
  localparam logic [OP_W-1:0] OP_RAMP_FIRST = 5'd11;

  typedef enum logic [1:0] {A_MONO, A_DRY, A_STMP, A_DIFF} a_src_e;
  typedef enum logic [1:0] {B_GAIN, B_WET, B_STEP} b_src_e;
  typedef enum logic [1:0] {SH_8, SH_12, SH_15, SH_16} shift_e;
  typedef enum logic [2:0] {D_DRY, D_SL, D_SR, D_STMP, D_SA, D_SB, D_SC, D_GAIN} dst_e;

  typedef struct packed {
    a_src_e              a_src;
    b_src_e              b_src;
    logic [GIDX_W-1:0]   gidx;
    shift_e              shift;
    dst_e                dst;
  } op_t;

  // Product schedule for one sample: dry chain, pan, three sends, then the
  // eight gain ramps in index order.
  function automatic op_t op_lookup(input logic [OP_W-1:0] op);
    op_t o;
    logic [OP_W-1:0] ramp_idx;
    ramp_idx = op - OP_RAMP_FIRST;
    o = '{a_src: A_DIFF, b_src: B_STEP, gidx: ramp_idx[GIDX_W-1:0], shift: SH_16,
          dst: D_GAIN};
    case (op)
      5'd0:  o = '{A_MONO, B_GAIN, GIDX_DRY,    SH_8,  D_DRY};
      5'd1:  o = '{A_DRY,  B_GAIN, GIDX_DIR,    SH_15, D_DRY};
      5'd2:  o = '{A_DRY,  B_GAIN, GIDX_DIST,   SH_15, D_DRY};
      5'd3:  o = '{A_DRY,  B_GAIN, GIDX_LEFT,   SH_15, D_SL};
      5'd4:  o = '{A_DRY,  B_GAIN, GIDX_RIGHT,  SH_15, D_SR};
      5'd5:  o = '{A_MONO, B_GAIN, GIDX_SEND_A, SH_12, D_STMP};
      5'd6:  o = '{A_STMP, B_WET,  GIDX_SEND_A, SH_12, D_SA};
      5'd7:  o = '{A_MONO, B_GAIN, GIDX_SEND_B, SH_12, D_STMP};
      5'd8:  o = '{A_STMP, B_WET,  GIDX_SEND_B, SH_12, D_SB};
      5'd9:  o = '{A_MONO, B_GAIN, GIDX_SEND_C, SH_12, D_STMP};
      5'd10: o = '{A_STMP, B_WET,  GIDX_SEND_C, SH_12, D_SC};
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic [4:0] sh_amount(input shift_e s);
    logic [4:0] n;
    case (s)
      SH_8:    n = 5'd8;
      SH_12:   n = 5'd12;
      SH_15:   n = 5'd15;
      SH_16:   n = 5'd16;
      default: n = 5'd16;
    endcase
    return n;
  endfunction

  // Send gains are signed, all others unsigned.
  function automatic logic signed [GAIN_W:0] gain_ext(input logic [GIDX_W-1:0] idx,
                                                      input logic [GAIN_W-1:0] g);
    return (idx >= GIDX_SEND_A) ? {g[GAIN_W-1], g} : {1'b0, g};
  endfunction

endpackage

FILE: rtl/sgsm_ifs.sv
// Request and result channel interfaces of the spatial mixer.
// Depends on sgsm_pkg for the gain width.
interface sgsm_req_if #(parameter int unsigned SAMPLE_BITS = 16);
  import sgsm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic [GAIN_W-1:0]             target_dry;
  logic [GAIN_W-1:0]             target_left;
  logic [GAIN_W-1:0]             target_right;
  logic [GAIN_W-1:0]             target_distance;
  logic [GAIN_W-1:0]             target_directivity;
  logic signed [GAIN_W-1:0]      target_send_a;
  logic signed [GAIN_W-1:0]      target_send_b;
  logic signed [GAIN_W-1:0]      target_send_c;

  modport source (output valid, req_type, left_in, right_in, target_dry, target_left,
                  target_right, target_distance, target_directivity, target_send_a,
                  target_send_b, target_send_c, input ready);
  modport sink (input valid, req_type, left_in, right_in, target_dry, target_left,
                target_right, target_distance, target_directivity, target_send_a,
                target_send_b, target_send_c, output ready);
endinterface

interface sgsm_res_if #(parameter int unsigned SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic signed [SAMPLE_BITS-1:0] send_a;
  logic signed [SAMPLE_BITS-1:0] send_b;
  logic signed [SAMPLE_BITS-1:0] send_c;

  modport source (output valid, out_left, out_right, send_a, send_b, send_c, input ready);
  modport sink (input valid, out_left, out_right, send_a, send_b, send_c, output ready);
endinterface

FILE: rtl/smoothed_gain_spatial_mixer.sv
// Smoothed-gain spatial mixer: each sample request gives one result with two dry outputs
// and three reverb sends; a target request loads new gain targets and gives no result.
// All 19 products of a sample (dry chain, pan, sends, eight gain ramps) run through one
// shared multiplier that takes its B operand four bits a cycle; each product has an
// operand load, five digit steps, and rounding with write-back, and a sample request
// holds the block from acceptance through all of its products until the next request
// can be taken. The result sits in an output register, so the next request is accepted
// while it waits. Depends on sgsm_pkg, sgsm_ifs and the assertion macro header.
`include "smoothed_gain_spatial_mixer_defines.svh"

module smoothed_gain_spatial_mixer #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sgsm_req_if.sink                            req_i,
  sgsm_res_if.source                          res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sgsm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sgsm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sgsm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import sgsm_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned AW = SB + GAIN_W;
  localparam int unsigned PW = AW + BOP_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [GAIN_W-1:0] cur_q [GAIN_COUNT];
  logic [GAIN_W-1:0] tgt_q [GAIN_COUNT];
  logic [15:0]       step_q, wet_q;
  logic              mute_q, spat_q;

  logic [OP_W-1:0]   op_q;
  logic [CNT_W-1:0]  cnt_q;

  logic signed [SB-1:0] mono_q;
  logic signed [AW-1:0] dry_q, sl_q, sr_q, stmp_q, sa_q, sb_q, sc_q;
  logic [BOP_W-1:0]     bsh_q;
  logic signed [PW-1:0] acc_q;

  logic                 out_valid_q;
  logic signed [SB-1:0] out_l_q, out_r_q, out_a_q, out_b_q, out_c_q;

  // Request and configuration handshakes.
  logic req_acc, smp_acc, tgt_acc, cfg_wr, out_load;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc = req_i.valid && req_i.ready;
  assign smp_acc = req_acc && !req_i.req_type;
  assign tgt_acc = req_acc && req_i.req_type;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);

  always_comb begin
    case (paddr[3:2])
      REG_STEP: prdata = {16'd0, step_q};
      REG_WET:  prdata = {16'd0, wet_q};
      REG_MUTE: prdata = {31'd0, mute_q};
      REG_SPAT: prdata = {31'd0, spat_q};
      default:  prdata = '0;
    endcase
  end

  // Downmix: floor of the average.
  logic signed [SB:0] lr_sum;
  assign lr_sum = {req_i.left_in[SB-1], req_i.left_in}
                + {req_i.right_in[SB-1], req_i.right_in};

  // Operand selection for the current product.
  op_t cur_op;
  logic [GAIN_W-1:0]       gain_sel, tgt_sel;
  logic signed [GAIN_W:0]  gain_s, tgt_s, diff_s;
  logic signed [AW-1:0]    a_op;
  logic [BOP_W-1:0]        b_op;

  assign cur_op   = op_lookup(op_q);
  assign gain_sel = cur_q[cur_op.gidx];
  assign tgt_sel  = tgt_q[cur_op.gidx];
  assign gain_s   = gain_ext(cur_op.gidx, gain_sel);
  assign tgt_s    = gain_ext(cur_op.gidx, tgt_sel);
  assign diff_s   = tgt_s - gain_s;

  always_comb begin
    case (cur_op.a_src)
      A_MONO:  a_op = {{(AW-SB){mono_q[SB-1]}}, mono_q};
      A_DRY:   a_op = dry_q;
      A_STMP:  a_op = stmp_q;
      A_DIFF:  a_op = {{(AW-GAIN_W-1){diff_s[GAIN_W]}}, diff_s};
      default: a_op = '0;
    endcase
    case (cur_op.b_src)
      B_GAIN:  b_op = {{(BOP_W-GAIN_W-1){gain_s[GAIN_W]}}, gain_s};
      B_WET:   b_op = {{(BOP_W-16){1'b0}}, wet_q};
      B_STEP:  b_op = {{(BOP_W-16){1'b0}}, step_q};
      default: b_op = '0;
    endcase
  end

  // One digit step: the leading digit carries the operand's sign.
  logic [DIG_W-1:0]         digit;
  logic signed [DIG_W:0]    digit_s;
  logic signed [AW+DIG_W:0] part;
  logic signed [PW-1:0]     acc_next;
  assign digit    = bsh_q[BOP_W-1 -: DIG_W];
  assign digit_s  = {(cnt_q == CNT_FIRST) ? digit[DIG_W-1] : 1'b0, digit};
  assign part     = a_op * digit_s;
  assign acc_next = (acc_q <<< DIG_W) + {{(PW-AW-DIG_W-1){part[AW+DIG_W]}}, part};

  // Round half up, then arithmetic shift.
  logic [4:0]           shamt;
  logic signed [PW-1:0] acc_rnd, rnd_full;
  logic signed [AW-1:0] res;
  logic [GAIN_W:0]      ramp_sum;
  assign shamt    = sh_amount(cur_op.shift);
  assign acc_rnd  = acc_q + (PW'(1) << (shamt - 5'd1));
  assign rnd_full = acc_rnd >>> shamt;
  assign res      = rnd_full[AW-1:0];
  assign ramp_sum = gain_s + res[GAIN_W:0];

  function automatic logic signed [SB-1:0] sat(input logic signed [AW-1:0] v);
    logic fits;
    fits = (v[AW-1:SB-1] == '0) || (v[AW-1:SB-1] == '1);
    if (fits) return v[SB-1:0];
    return v[AW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (smp_acc) state_d = ST_CALC;
      ST_CALC: if (cnt_q == CNT_WB && op_q == OP_LAST) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, gains and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      cnt_q       <= CNT_LOAD;
      out_valid_q <= 1'b0;
      step_q      <= STEP_RST;
      wet_q       <= WET_RST;
      mute_q      <= 1'b0;
      spat_q      <= 1'b1;
      for (int i = 0; i < GAIN_COUNT; i++) begin
        cur_q[i] <= '0;
        tgt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_STEP: step_q <= pwdata[15:0];
          REG_WET:  wet_q  <= pwdata[15:0];
          REG_MUTE: mute_q <= pwdata[0];
          REG_SPAT: spat_q <= pwdata[0];
          default: ;
        endcase
      end
      if (tgt_acc) begin
        tgt_q[GIDX_DRY]    <= (req_i.target_dry < MIN_DRY_GAIN) ? MIN_DRY_GAIN
                                                                : req_i.target_dry;
        tgt_q[GIDX_LEFT]   <= req_i.target_left;
        tgt_q[GIDX_RIGHT]  <= req_i.target_right;
        tgt_q[GIDX_DIST]   <= req_i.target_distance;
        tgt_q[GIDX_DIR]    <= req_i.target_directivity;
        tgt_q[GIDX_SEND_A] <= req_i.target_send_a;
        tgt_q[GIDX_SEND_B] <= req_i.target_send_b;
        tgt_q[GIDX_SEND_C] <= req_i.target_send_c;
      end
      if (smp_acc) begin
        op_q  <= '0;
        cnt_q <= CNT_LOAD;
      end else if (state_q == ST_CALC) begin
        if (cnt_q == CNT_WB) begin
          cnt_q <= CNT_LOAD;
          if (op_q != OP_LAST) op_q <= op_q + 5'd1;
          if (cur_op.dst == D_GAIN) cur_q[cur_op.gidx] <= ramp_sum[GAIN_W-1:0];
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (smp_acc) mono_q <= lr_sum[SB:1];
    if (state_q == ST_CALC) begin
      if (cnt_q == CNT_LOAD) begin
        bsh_q <= b_op;
        acc_q <= '0;
      end else if (cnt_q != CNT_WB) begin
        bsh_q <= bsh_q << DIG_W;
        acc_q <= acc_next;
      end else begin
        case (cur_op.dst)
          D_DRY:   dry_q  <= res;
          D_SL:    sl_q   <= res;
          D_SR:    sr_q   <= res;
          D_STMP:  stmp_q <= res;
          D_SA:    sa_q   <= res;
          D_SB:    sb_q   <= res;
          D_SC:    sc_q   <= res;
          default: ;
        endcase
      end
    end
    if (out_load) begin
      out_l_q <= mute_q ? '0 : sat(spat_q ? sl_q : dry_q);
      out_r_q <= mute_q ? '0 : sat(spat_q ? sr_q : dry_q);
      out_a_q <= sat(sa_q);
      out_b_q <= sat(sb_q);
      out_c_q <= sat(sc_q);
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.out_left  = out_l_q;
  assign res_o.out_right = out_r_q;
  assign res_o.send_a    = out_a_q;
  assign res_o.send_b    = out_b_q;
  assign res_o.send_c    = out_c_q;

  `SGSM_ASSERT_NXT(a_sample_starts, smp_acc, (state_q == ST_CALC) && (op_q == '0) && (cnt_q == CNT_LOAD), "sample request did not start the product schedule")
  `SGSM_ASSERT_NXT(a_target_no_work, tgt_acc, state_q == ST_IDLE, "target request started work")
  `SGSM_ASSERT_IMP(a_sched_bounds, state_q == ST_CALC, (op_q <= OP_LAST) && (cnt_q <= CNT_WB), "product schedule out of range")
  `SGSM_ASSERT_IMP(a_done_at_end, state_q == ST_DONE, (op_q == OP_LAST) && (cnt_q == CNT_LOAD), "result ready before the last product")

endmodule
